/* hdl/ptlb_pkg.sv */
// ----------------------------------------------------------------------------
// ptlb_pkg
// shared types and constants of the per-task line buffer transmit mux
// ----------------------------------------------------------------------------
package ptlb_pkg;

   localparam int unsigned TASK_ID_W = 3;
   localparam int unsigned CHAR_W    = 8;
   localparam int unsigned STATUS_W  = 2;

   localparam logic [CHAR_W-1:0] NEWLINE_CODE = 8'd10;

   localparam logic KIND_CHAR     = 1'b0;
   localparam logic KIND_TX_READY = 1'b1;

   localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_TASK_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TX_OVF   = 2'd2;

   typedef struct packed {
      logic                 kind;
      logic [TASK_ID_W-1:0] task_id;
      logic [CHAR_W-1:0]    char_code;
   } req_type;

   typedef struct packed {
      logic                tx_valid;
      logic [CHAR_W-1:0]   tx_char;
      logic [STATUS_W-1:0] status;
      logic                tx_pending;
   } rsp_type;

   typedef enum logic [1:0] {
      OP_PUSH,
      OP_DROP,
      OP_POP
   } op_type;

   // classified command from front to back
   typedef struct packed {
      op_type               op;
      logic [TASK_ID_W-1:0] task_id;
      logic [CHAR_W-1:0]    char_code;
   } cmd_type;

endpackage

/* hdl/ptlb_front.sv */
// ----------------------------------------------------------------------------
// ptlb_front
// accepts items, classifies them and queues commands for the back end
// ----------------------------------------------------------------------------
module ptlb_front #(
   parameter int unsigned NUM_TASKS = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ptlb_pkg::req_type req_data,
   output logic              cmd_valid,
   input  logic              cmd_ready,
   output ptlb_pkg::cmd_type cmd_data
);
   import ptlb_pkg::*;

   cmd_type q_ff [2];
   cmd_type q_in;
   logic    wr_ptr_ff, rd_ptr_ff;
   logic [1:0] cnt_ff;
   logic    push, pop;

   assign req_ready = (cnt_ff != 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data  = q_ff[rd_ptr_ff];
   assign push      = req_valid && req_ready;
   assign pop       = cmd_valid && cmd_ready;

   always_comb begin
      q_in.task_id   = req_data.task_id;
      q_in.char_code = req_data.char_code;
      if (req_data.kind == KIND_TX_READY) begin
         q_in.op = OP_POP;
      end else if (32'(req_data.task_id) >= NUM_TASKS) begin
         q_in.op = OP_DROP;
      end else begin
         q_in.op = OP_PUSH;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= q_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= ~wr_ptr_ff;
         if (pop)  rd_ptr_ff <= ~rd_ptr_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

endmodule

/* hdl/ptlb_back.sv */
// ----------------------------------------------------------------------------
// ptlb_back
// executes commands on the task fifos and the shared transmit fifo
// ----------------------------------------------------------------------------
module ptlb_back #(
   parameter int unsigned NUM_TASKS  = 8,
   parameter int unsigned FIFO_DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   output logic              cmd_ready,
   input  ptlb_pkg::cmd_type cmd_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ptlb_pkg::rsp_type rsp_data
);
   import ptlb_pkg::*;

   localparam int unsigned PW = $clog2(FIFO_DEPTH);
   localparam int unsigned CW = PW + 1;
   localparam int unsigned TW = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int unsigned AW = TW + PW;
   localparam int unsigned TS = 1 << TW;
   localparam int unsigned DS = 1 << PW;

   typedef enum logic [2:0] {
      S_IDLE,
      S_MOVE_RD,
      S_MOVE_WR,
      S_POP_RD,
      S_RESP
   } state_type;

   logic [CHAR_W-1:0] task_mem [TS*DS];
   logic [CHAR_W-1:0] tx_mem   [DS];

   state_type         state_ff;
   logic [PW-1:0]     thead_ff [NUM_TASKS];
   logic [CW-1:0]     tcnt_ff  [NUM_TASKS];
   logic [PW-1:0]     xhead_ff;
   logic [CW-1:0]     xcnt_ff;
   logic [TW-1:0]     tid_ff;
   logic [STATUS_W-1:0] stat_ff;
   logic [CHAR_W-1:0] rd_ff;
   logic [CHAR_W-1:0] xrd_ff;
   rsp_type           rsp_ff;
   logic              rsp_valid_ff;

   logic [TW-1:0]     tid;
   logic [PW-1:0]     th, tslot;
   logic [CW-1:0]     tc;
   logic [PW-1:0]     xslot;
   logic              t_rd_en, t_wr_en, x_wr_en, x_rd_en;
   logic [AW-1:0]     t_rd_addr, t_wr_addr;

   assign tid   = (state_ff == S_IDLE) ? TW'(cmd_data.task_id) : tid_ff;
   assign th    = thead_ff[tid];
   assign tc    = tcnt_ff[tid];
   assign tslot = th + tc[PW-1:0];
   assign xslot = xhead_ff + xcnt_ff[PW-1:0];

   assign cmd_ready = (state_ff == S_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   assign t_wr_en   = cmd_valid && cmd_ready && (cmd_data.op == OP_PUSH)
                      && (tc != CW'(FIFO_DEPTH));
   assign t_wr_addr = {tid, tslot};
   assign t_rd_en   = (state_ff == S_MOVE_RD);
   assign t_rd_addr = {tid_ff, th};
   assign x_wr_en   = (state_ff == S_MOVE_WR) && (xcnt_ff != CW'(FIFO_DEPTH));
   assign x_rd_en   = cmd_valid && cmd_ready && (cmd_data.op == OP_POP);

   always_ff @(posedge clock) begin
      if (t_wr_en) task_mem[t_wr_addr] <= cmd_data.char_code;
      if (t_rd_en) rd_ff <= task_mem[t_rd_addr];
   end

   always_ff @(posedge clock) begin
      if (x_wr_en) tx_mem[xslot] <= rd_ff;
      if (x_rd_en) xrd_ff <= tx_mem[xhead_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         xhead_ff     <= '0;
         xcnt_ff      <= '0;
         tid_ff       <= '0;
         stat_ff      <= STATUS_OK;
         rsp_ff       <= '0;
         for (int i = 0; i < NUM_TASKS; i++) begin
            thead_ff[i] <= '0;
            tcnt_ff[i]  <= '0;
         end
      end else begin
         if (rsp_valid_ff && rsp_ready) rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            S_IDLE: begin
               if (cmd_valid && cmd_ready) begin
                  tid_ff  <= tid;
                  stat_ff <= STATUS_OK;
                  unique case (cmd_data.op)
                     OP_DROP: begin
                        stat_ff  <= STATUS_TASK_FULL;
                        state_ff <= S_RESP;
                     end
                     OP_PUSH: begin
                        if (tc == CW'(FIFO_DEPTH)) begin
                           stat_ff  <= STATUS_TASK_FULL;
                           state_ff <= S_RESP;
                        end else begin
                           tcnt_ff[tid] <= tc + 1'b1;
                           state_ff <= (cmd_data.char_code == NEWLINE_CODE)
                                       ? S_MOVE_RD : S_RESP;
                        end
                     end
                     OP_POP: begin
                        state_ff <= S_POP_RD;
                     end
                     default: state_ff <= S_RESP;
                  endcase
               end
            end
            S_MOVE_RD: begin
               thead_ff[tid_ff] <= th + 1'b1;
               tcnt_ff[tid_ff]  <= tc - 1'b1;
               state_ff         <= S_MOVE_WR;
            end
            S_MOVE_WR: begin
               if (xcnt_ff != CW'(FIFO_DEPTH)) begin
                  xcnt_ff <= xcnt_ff + 1'b1;
               end else begin
                  stat_ff <= STATUS_TX_OVF;
               end
               if (rd_ff == NEWLINE_CODE || tc == '0) begin
                  state_ff <= S_RESP;
               end else begin
                  state_ff <= S_MOVE_RD;
               end
            end
            S_POP_RD: begin
               rsp_ff.status <= STATUS_OK;
               if (xcnt_ff != '0) begin
                  rsp_ff.tx_valid   <= 1'b1;
                  rsp_ff.tx_char    <= xrd_ff;
                  rsp_ff.tx_pending <= (xcnt_ff != CW'(1));
                  xhead_ff          <= xhead_ff + 1'b1;
                  xcnt_ff           <= xcnt_ff - 1'b1;
               end else begin
                  rsp_ff.tx_valid   <= 1'b0;
                  rsp_ff.tx_char    <= '0;
                  rsp_ff.tx_pending <= 1'b0;
               end
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
            S_RESP: begin
               rsp_ff.tx_valid   <= 1'b0;
               rsp_ff.tx_char    <= '0;
               rsp_ff.status     <= stat_ff;
               rsp_ff.tx_pending <= (xcnt_ff != '0);
               rsp_valid_ff      <= 1'b1;
               state_ff          <= S_IDLE;
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

/* hdl/per_task_line_buffer_tx_mux.sv */
// ----------------------------------------------------------------------------
// per_task_line_buffer_tx_mux
// console mux with one line fifo per task and a shared transmit fifo
// ----------------------------------------------------------------------------
// req channel carries either a character from a task (kind 0) or a
// transmitter-ready request (kind 1); every transaction gives exactly one
// rsp transaction. a character is appended to its task fifo; a newline moves
// that task's line into the transmit fifo one byte at a time through the
// task memory read port. a transmitter-ready pops one byte from the transmit
// fifo and reports whether more remain.
// a plain character or a drop passes through S_RESP, a pop through S_POP_RD,
// and a newline through S_MOVE_RD then S_MOVE_WR per moved byte, then S_RESP.
// the back end works on one transaction at a time; a two-entry queue in front
// keeps taking transactions while the back end is busy.
// reset clears all fifo pointers and counts; memories are not cleared.
// a stalled rsp holds its result and the back end waits until it is taken.
module per_task_line_buffer_tx_mux #(
   parameter int unsigned NUM_TASKS  = 8,
   parameter int unsigned FIFO_DEPTH = 256
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  ptlb_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output ptlb_pkg::rsp_type rsp_data
);
   import ptlb_pkg::*;

   logic    cmd_valid, cmd_ready;
   cmd_type cmd_data;

   ptlb_front #(.NUM_TASKS(NUM_TASKS)) u_front (
      .clock, .reset, .req_valid, .req_ready, .req_data,
      .cmd_valid, .cmd_ready, .cmd_data
   );

   ptlb_back #(.NUM_TASKS(NUM_TASKS), .FIFO_DEPTH(FIFO_DEPTH)) u_back (
      .clock, .reset, .cmd_valid, .cmd_ready, .cmd_data,
      .rsp_valid, .rsp_ready, .rsp_data
   );

endmodule

/* tb/tb_per_task_line_buffer_tx_mux.sv */
// ----------------------------------------------------------------------------
// tb_per_task_line_buffer_tx_mux
// self-checking bench: directed table, fill and overflow runs, then random task lines and tx pops,
// every response compared with an in-bench model of the per-task line fifos
// ----------------------------------------------------------------------------
module tb_per_task_line_buffer_tx_mux;
   timeunit 1ns;
   timeprecision 1ps;
   import ptlb_pkg::*;

   localparam int NTASK = 8;
   localparam int DEPTH = 256;
   localparam int WATCHDOG_LIMIT = 20000;
   localparam int NUM_RANDOM = 220;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_data;

   per_task_line_buffer_tx_mux #(.NUM_TASKS(NTASK), .FIFO_DEPTH(DEPTH)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_data(rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // model state
   logic [7:0] line_q[NTASK][$];
   logic [7:0] tx_q[$];
   rsp_type    expected_rsp_q[$];

   int  error_count = 0;
   int  idle_count = 0;
   bit  no_idle = 1'b0;
   bit  hold_rsp = 1'b0;

   function automatic rsp_type predict_console(req_type r);
      rsp_type o;
      logic [7:0] c;
      o = '0;
      if (r.kind == KIND_CHAR) begin
         if (line_q[r.task_id].size() >= DEPTH) begin
            o.status = STATUS_TASK_FULL;
         end else begin
            line_q[r.task_id].push_back(r.char_code);
            if (r.char_code == NEWLINE_CODE) begin
               while (line_q[r.task_id].size() != 0) begin
                  c = line_q[r.task_id].pop_front();
                  if (tx_q.size() < DEPTH) tx_q.push_back(c);
                  else o.status = STATUS_TX_OVF;
                  if (c == NEWLINE_CODE) break;
               end
            end
         end
      end else if (tx_q.size() != 0) begin
         o.tx_valid = 1'b1;
         o.tx_char = tx_q.pop_front();
      end
      o.tx_pending = (tx_q.size() != 0);
      return o;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d", what, got, want);
      error_count++;
   endtask

   task automatic send_transaction(req_type r, bit fixed, rsp_type want);
      rsp_type p;
      while (!no_idle && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      p = predict_console(r);
      if (fixed && p != want) report_mismatch("directed row", int'(p), int'(want));
      expected_rsp_q.push_back(p);
      req_valid <= 1'b1;
      req_data <= r;
      do @(posedge clock); while (!req_ready);
   endtask

   function automatic req_type mk(logic k, logic [2:0] t, logic [7:0] c);
      req_type r;
      r.kind = k; r.task_id = t; r.char_code = c;
      return r;
   endfunction

   // response side
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            idle_count <= 0;
            if (expected_rsp_q.size() == 0) begin
               report_mismatch("unexpected transaction", int'(rsp_data), 0);
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data.tx_valid != want.tx_valid)
                  report_mismatch("tx_valid", int'(rsp_data.tx_valid),
                                  int'(want.tx_valid));
               if (rsp_data.tx_char != want.tx_char)
                  report_mismatch("tx_char", int'(rsp_data.tx_char), int'(want.tx_char));
               if (rsp_data.status != want.status)
                  report_mismatch("status", int'(rsp_data.status), int'(want.status));
               if (rsp_data.tx_pending != want.tx_pending)
                  report_mismatch("tx_pending", int'(rsp_data.tx_pending),
                                  int'(want.tx_pending));
            end
         end else if (req_valid && req_ready) begin
            idle_count <= 0;
         end else begin
            idle_count <= idle_count + 1;
         end
         rsp_ready <= !hold_rsp && (no_idle || $urandom_range(99) >= 19);
      end
   end

   always @(posedge clock) begin
      if (idle_count >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   typedef struct {
      req_type r;
      bit      fixed;
      rsp_type want;
   } row_type;

   initial begin
      row_type rows[$];
      req_type r;
      int t, n, len;
      rsp_type z;
      z = '0;
      for (int i = 0; i < NTASK; i++) line_q[i] = {};
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table
      rows.push_back('{mk(KIND_TX_READY, 3'd5, 8'hff), 1, z});
      rows.push_back('{mk(KIND_CHAR, 3'd0, 8'h00), 1, z});
      rows.push_back('{mk(KIND_CHAR, 3'd7, 8'hff), 1, z});
      rows.push_back('{mk(KIND_CHAR, 3'd7, NEWLINE_CODE), 0, z});
      rows.push_back('{mk(KIND_CHAR, 3'd0, 8'h55), 0, z});
      rows.push_back('{mk(KIND_CHAR, 3'd3, 8'haa), 0, z});
      rows.push_back('{mk(KIND_CHAR, 3'd0, NEWLINE_CODE), 0, z});
      rows.push_back('{mk(KIND_CHAR, 3'd3, NEWLINE_CODE), 0, z});
      for (int i = 0; i < 8; i++) rows.push_back('{mk(KIND_TX_READY, 3'(i), 8'(i)), 0, z});
      rows.push_back('{mk(KIND_CHAR, 3'd2, NEWLINE_CODE), 0, z});
      rows.push_back('{mk(KIND_TX_READY, 3'd0, 8'h00), 0, z});
      rows.push_back('{mk(KIND_TX_READY, 3'd0, 8'h00), 1, z});
      foreach (rows[i]) send_transaction(rows[i].r, rows[i].fixed, rows[i].want);

      // fill task 4 past full: drops, dropped newline, then tx overflow
      no_idle = 1'b1;
      for (int i = 0; i < DEPTH + 2; i++)
         send_transaction(mk(KIND_CHAR, 3'd4, (i == DEPTH) ? NEWLINE_CODE : 8'(i | 8'h20)),
                          0, z);
      for (int i = 0; i < 40; i++) send_transaction(mk(KIND_CHAR, 3'd6, 8'h41), 0, z);
      for (int i = 0; i < DEPTH - 1; i++)
         send_transaction(mk(KIND_CHAR, 3'd1, 8'h30 + 8'(i % 64)), 0, z);
      send_transaction(mk(KIND_CHAR, 3'd1, NEWLINE_CODE), 0, z);
      send_transaction(mk(KIND_CHAR, 3'd6, NEWLINE_CODE), 0, z);
      // long receiver hold while the sender keeps pushing
      fork
         begin
            hold_rsp = 1'b1;
            repeat (300) @(posedge clock);
            hold_rsp = 1'b0;
         end
         for (int i = 0; i < 20; i++) send_transaction(mk(KIND_TX_READY, 3'd0, 8'h00), 0, z);
      join
      // drain tx fifo
      while (tx_q.size() != 0) send_transaction(mk(KIND_TX_READY, 3'(tx_q.size()), 8'h00), 0, z);
      no_idle = 1'b0;

      // random: short lines with random content, mixed with pops and noise
      n = 0;
      while (n < NUM_RANDOM) begin
         if (n > 80 && n < 140) no_idle = 1'b1; else no_idle = 1'b0;
         case ($urandom_range(9))
            0, 1, 2, 3: begin
               t = $urandom_range(NTASK - 1);
               len = $urandom_range(6);
               for (int i = 0; i < len; i++) begin
                  r = mk(KIND_CHAR, 3'(t), 8'($urandom_range(255)));
                  if (r.char_code == NEWLINE_CODE) r.char_code = 8'h7e;
                  send_transaction(r, 0, z);
                  n++;
               end
               send_transaction(mk(KIND_CHAR, 3'(t), NEWLINE_CODE), 0, z);
               n++;
            end
            4: begin
               send_transaction(mk(KIND_CHAR, 3'($urandom_range(7)), 8'($urandom_range(255))),
                                0, z);
               n++;
            end
            default: begin
               send_transaction(mk(KIND_TX_READY, 3'($urandom_range(7)),
                                   8'($urandom_range(255))), 0, z);
               n++;
            end
         endcase
      end
      req_valid <= 1'b0;
      while (expected_rsp_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end
endmodule

/* files.f */
hdl/ptlb_pkg.sv
hdl/ptlb_front.sv
hdl/ptlb_back.sv
hdl/per_task_line_buffer_tx_mux.sv
tb/tb_per_task_line_buffer_tx_mux.sv
